// ===== hdl/cpd_pkg.sv =====
// Shared types and constants for the COBS packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package cpd_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned CountWidth   = 9;

  typedef enum logic [2:0] {
    REG_START_MARKER    = 3'd0,
    REG_WAYPOINT_ID     = 3'd1,
    REG_WAYPOINT_LENGTH = 3'd2,
    REG_SETTINGS_ID     = 3'd3,
    REG_SETTINGS_LENGTH = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] waypoint_id;
    logic [7:0] waypoint_length;
    logic [7:0] settings_id;
    logic [7:0] settings_length;
  } cfg_t;

  typedef struct packed {
    logic                  inside_packet;
    logic [CountWidth-1:0] received_count;
    logic [7:0]            payload_length;
    logic [7:0]            current_id;
    logic [7:0]            group_remaining;
    logic                  group_was_full;
    logic [7:0]            decoded_count;
  } deframe_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [7:0] byte_position;
    logic [7:0] message_id;
    logic       last;
    logic       accepted;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/cpd_step.sv =====
// Per-byte framing and COBS decode step: next state and optional result.
`timescale 1ns / 1ps
`default_nettype none
module cpd_step (
  input  wire cpd_pkg::cfg_t           cfg,
  input  wire cpd_pkg::deframe_state_t state,
  input  wire logic [7:0]              rx_byte,
  input  wire logic                    in_config_mode,
  output cpd_pkg::deframe_state_t      state_next,
  output logic                         has_result,
  output cpd_pkg::result_t             result
);

  localparam logic [cpd_pkg::CountWidth-1:0] CountHeader =
    cpd_pkg::CountWidth'(cpd_pkg::HEADER_BYTES);

  logic [cpd_pkg::CountWidth-1:0] count_inc;
  logic [cpd_pkg::CountWidth-1:0] end_count;
  logic                           ends;
  logic                           qualifies;
  logic                           is_wp;
  logic                           is_st;

  assign count_inc = state.received_count + 1'b1;
  assign end_count = {1'b0, state.payload_length} + CountHeader;

  always_comb begin
    state_next = state;
    has_result = 1'b0;
    result     = '0;
    result.message_id = state.current_id;

    if (!state.inside_packet) begin
      if (rx_byte == cfg.start_marker) begin
        state_next.inside_packet  = 1'b1;
        state_next.received_count = cpd_pkg::CountWidth'(1);
      end
    end else begin
      state_next.received_count = count_inc;
      if (count_inc == cpd_pkg::CountWidth'(2)) begin
        state_next.payload_length = rx_byte;
      end else if (count_inc == cpd_pkg::CountWidth'(3)) begin
        state_next.current_id = rx_byte;
        result.message_id     = rx_byte;
      end else begin
        if (count_inc == CountHeader) begin
          // first code byte; only a zero-length packet reports here
          state_next.group_remaining = (rx_byte == 8'd0) ? 8'd1 : rx_byte;
          state_next.group_was_full  = (rx_byte == 8'hFF);
          state_next.decoded_count   = '0;
          has_result = (state.payload_length == 8'd0);
        end else if (state.group_remaining > 8'd1) begin
          result.data_byte           = rx_byte;
          result.data_valid          = 1'b1;
          result.byte_position       = state.decoded_count;
          state_next.decoded_count   = state.decoded_count + 1'b1;
          state_next.group_remaining = state.group_remaining - 1'b1;
          has_result = 1'b1;
        end else begin
          // new code byte: implied zero unless the previous group was full
          if (!state.group_was_full) begin
            result.data_valid        = 1'b1;
            result.byte_position     = state.decoded_count;
            state_next.decoded_count = state.decoded_count + 1'b1;
          end
          state_next.group_remaining = (rx_byte == 8'd0) ? 8'd1 : rx_byte;
          state_next.group_was_full  = (rx_byte == 8'hFF);
          has_result = 1'b1;
        end
        if (has_result && ends) begin
          result.last               = 1'b1;
          result.accepted           = qualifies;
          state_next.inside_packet  = 1'b0;
          state_next.received_count = '0;
        end
      end
    end
  end

  assign ends      = (count_inc == end_count);
  assign is_wp     = (state.current_id == cfg.waypoint_id) &&
                     (state.payload_length == cfg.waypoint_length);
  assign is_st     = (state.current_id == cfg.settings_id) &&
                     (state.payload_length == cfg.settings_length);
  assign qualifies = in_config_mode && (is_wp || is_st);

endmodule
`default_nettype wire

// ===== hdl/cobs_packet_deframer.sv =====
// Top level: COBS packet deframer with config registers and output register.
// Latency: a result is presented the cycle after the transfer of the byte that causes it.
// Throughput: one byte per cycle; input stalls only while a held result is stalled.
// Header bytes (start, length, id, and the first code of a non-empty packet) give no result.
// Reset (rst, synchronous, active high) clears framing state and output valid,
// and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none
module cobs_packet_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write port
  input  wire logic       cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  // received byte channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       in_config_mode,
  // decoded result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_byte,
  output logic            data_valid,
  output logic [7:0]      byte_position,
  output logic [7:0]      message_id,
  output logic            last,
  output logic            accepted
);

  cpd_pkg::cfg_t           cfg;
  cpd_pkg::deframe_state_t state;
  cpd_pkg::deframe_state_t state_next;
  cpd_pkg::result_t        result_next;
  cpd_pkg::result_t        result;
  logic                    has_result;
  logic                    in_xfer;
  logic                    out_xfer;

  // The output register frees up in the same cycle its result transfers,
  // so a new byte can be taken every cycle unless the sink is stalling.
  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker    <= 8'd0;
      cfg.waypoint_id     <= 8'd1;
      cfg.waypoint_length <= 8'd0;
      cfg.settings_id     <= 8'd2;
      cfg.settings_length <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        cpd_pkg::REG_START_MARKER:    cfg.start_marker    <= cfg_data;
        cpd_pkg::REG_WAYPOINT_ID:     cfg.waypoint_id     <= cfg_data;
        cpd_pkg::REG_WAYPOINT_LENGTH: cfg.waypoint_length <= cfg_data;
        cpd_pkg::REG_SETTINGS_ID:     cfg.settings_id     <= cfg_data;
        cpd_pkg::REG_SETTINGS_LENGTH: cfg.settings_length <= cfg_data;
        default: ;
      endcase
    end
  end

  cpd_step u_step (
    .cfg            (cfg),
    .state          (state),
    .rx_byte        (rx_byte),
    .in_config_mode (in_config_mode),
    .state_next     (state_next),
    .has_result     (has_result),
    .result         (result_next)
  );

  // Framing state advances on every input transfer, result or not.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && has_result) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && has_result) begin
      result <= result_next;
    end
  end

  assign data_byte     = result.data_byte;
  assign data_valid    = result.data_valid;
  assign byte_position = result.byte_position;
  assign message_id    = result.message_id;
  assign last          = result.last;
  assign accepted      = result.accepted;

endmodule
`default_nettype wire
